/* hdl/ascii_power_command_decoder_assert.svh */
`ifndef ASCII_POWER_COMMAND_DECODER_ASSERT_SVH
`define ASCII_POWER_COMMAND_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define APCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apcd assertion failed");

// next-cycle implication, checked outside reset
`define APCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apcd assertion failed");

`endif

/* hdl/apcd_pkg.sv */
package apcd_pkg;

  localparam int LINE_MAX        = 40;
  localparam int MAX_PARAM_CHARS = 5;
  localparam int NAME_COUNT      = 5;
  localparam int NAME_LEN_MAX    = 11;
  localparam int SETV_LEN        = 11;

  localparam int BYTE_W     = 8;
  localparam int LINE_POS_W = $clog2(LINE_MAX + 1);
  localparam int PCNT_W     = $clog2(MAX_PARAM_CHARS + 1);
  localparam int NAME_POS_W = $clog2(NAME_LEN_MAX + 1);
  localparam int MV_W       = 17;
  localparam int STEP_W     = 4;
  localparam int DAC_W      = 15;
  localparam int ACC_EXT_W  = MV_W + 4;

  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;

  localparam logic [MV_W-1:0]  VALUE_CAP = 17'd99999;
  localparam logic [DAC_W-1:0] DAC_MAX   = 15'd17066;

  // dac = floor(mv * 64 / 375); reciprocal estimate is low by at most one
  localparam int                DAC_SHIFT = 24;
  localparam logic [21:0]       DAC_RECIP = 22'd2863311;
  localparam int                DAC_DIV   = 375;
  localparam int                DAC_PROD_W = MV_W + 22;
  localparam int                DAC_NUM_W  = MV_W + 6;

  // step thresholds on millivolts (ladder on mv + 1000 from 5000 up to 12000)
  localparam int STEP_COUNT = 8;
  localparam logic [MV_W-1:0] STEP_THRESH [STEP_COUNT] = '{
    17'd4000, 17'd5000, 17'd6000, 17'd7000,
    17'd8000, 17'd9000, 17'd10000, 17'd11000
  };

  localparam logic [NAME_LEN_MAX*BYTE_W-1:0] NAME_TEXT [NAME_COUNT] = '{
    "power on   ", "power off  ", "set voltage", "get voltage", "get current"
  };
  localparam logic [NAME_POS_W-1:0] NAME_LEN [NAME_COUNT] = '{
    4'd8, 4'd9, 4'd11, 4'd11, 4'd11
  };

  localparam int CMD_FIFO_DEPTH = 2;
  localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
  localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_POWER_ON    = 3'd0,
    CMD_POWER_OFF   = 3'd1,
    CMD_SET_VOLTAGE = 3'd2,
    CMD_GET_VOLTAGE = 3'd3,
    CMD_GET_CURRENT = 3'd4,
    CMD_INVALID     = 3'd5
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t       code;
    logic            value_valid;
    logic [MV_W-1:0] millivolts;
  } cmd_t;

  typedef struct packed {
    logic [DAC_W-1:0]  dac_code;
    logic [STEP_W-1:0] supply_step;
    logic [MV_W-1:0]   millivolts;
    logic              value_valid;
    cmd_code_t         command_code;
  } result_t;

  function automatic logic [BYTE_W-1:0] name_char(input int k,
                                                  input logic [NAME_POS_W-1:0] pos);
    logic [BYTE_W-1:0] ch;
    ch = '0;
    if (pos < NAME_POS_W'(NAME_LEN_MAX)) begin
      ch = NAME_TEXT[k][(NAME_LEN_MAX - 1 - int'(pos)) * BYTE_W +: BYTE_W];
    end
    return ch;
  endfunction

endpackage

/* hdl/ascii_power_command_decoder.sv */
// Decodes a console byte stream into power-supply commands, one byte per clock
// cycle sustained. Each line ends at LF; a line that is not empty and shorter
// than 40 bytes gives one result word carrying the command code and, for
// "set voltage" with a space separator, the millivolt value, supply step and
// DAC code. The line matcher updates in the cycle of each byte; the command of a
// line is written into a two-word queue when its LF is taken, and the queue hands
// it to a two-stage back end (reciprocal multiply, then correction). Input stalls
// only when that queue is full; the output register lets new bytes flow while a
// result waits.
module ascii_power_command_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // dac_code, supply_step, millivolts, value_valid, command_code
);

  logic              accept;
  logic              push, fifo_full, fifo_valid, back_ready;
  apcd_pkg::cmd_t    push_cmd, fifo_cmd;
  apcd_pkg::result_t result;

  assign s_tready = !fifo_full;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = result;

  apcd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (s_tdata),
    .push     (push),
    .push_cmd (push_cmd)
  );

  apcd_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (fifo_full),
    .pop       (back_ready),
    .pop_valid (fifo_valid),
    .pop_cmd   (fifo_cmd)
  );

  apcd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (fifo_valid),
    .in_cmd     (fifo_cmd),
    .in_ready   (back_ready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

`include "ascii_power_command_decoder_assert.svh"

  `APCD_ASSERT_NOW(a_unused_fields_zero, m_tvalid && !result.value_valid,
    result.millivolts == '0 && result.supply_step == '0 && result.dac_code == '0)
  `APCD_ASSERT_NOW(a_value_only_set, m_tvalid && result.value_valid,
    result.command_code == apcd_pkg::CMD_SET_VOLTAGE)
  `APCD_ASSERT_NOW(a_dac_range, m_tvalid, result.dac_code <= apcd_pkg::DAC_MAX)
  `APCD_ASSERT_NEXT(a_push_reaches_queue, push && !fifo_full, fifo_valid)

endmodule

/* hdl/apcd_front.sv */
module apcd_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [apcd_pkg::BYTE_W-1:0] rx_byte,
  output logic                       push,
  output apcd_pkg::cmd_t             push_cmd
);

  logic [apcd_pkg::LINE_POS_W-1:0] line_position, line_position_next;
  logic [apcd_pkg::NAME_COUNT-1:0] name_match_flags, name_match_flags_next;
  logic                            separator_was_space, separator_was_space_next;
  logic [apcd_pkg::PCNT_W-1:0]     param_char_count, param_char_count_next;
  logic [apcd_pkg::MV_W-1:0]       value_accumulator, value_accumulator_next;
  logic                            line_overflowed, line_overflowed_next;
  logic                            carriage_return_seen, carriage_return_seen_next;

  logic [apcd_pkg::ACC_EXT_W-1:0]  acc_ext;
  apcd_pkg::cmd_code_t             code_sel;
  logic                            is_digit;

  always_comb begin
    code_sel = apcd_pkg::CMD_INVALID;
    for (int k = apcd_pkg::NAME_COUNT - 1; k >= 0; k--) begin
      if (name_match_flags[k] &&
          line_position >= apcd_pkg::LINE_POS_W'(apcd_pkg::NAME_LEN[k])) begin
        code_sel = apcd_pkg::cmd_code_t'(3'(k));
      end
    end
  end

  assign is_digit = (rx_byte >= apcd_pkg::CH_ZERO) && (rx_byte <= apcd_pkg::CH_NINE);
  assign acc_ext  = apcd_pkg::ACC_EXT_W'(value_accumulator) * apcd_pkg::ACC_EXT_W'(10)
                  + apcd_pkg::ACC_EXT_W'(rx_byte[3:0]);

  always_comb begin
    line_position_next        = line_position;
    name_match_flags_next     = name_match_flags;
    separator_was_space_next  = separator_was_space;
    param_char_count_next     = param_char_count;
    value_accumulator_next    = value_accumulator;
    line_overflowed_next      = line_overflowed;
    carriage_return_seen_next = carriage_return_seen;
    push                      = 1'b0;
    push_cmd.code             = code_sel;
    push_cmd.value_valid      = (code_sel == apcd_pkg::CMD_SET_VOLTAGE) && separator_was_space;
    push_cmd.millivolts       = push_cmd.value_valid ? value_accumulator : '0;

    if (accept) begin
      if (rx_byte == apcd_pkg::CH_LF) begin
        push                      = !line_overflowed && (line_position != '0);
        line_position_next        = '0;
        name_match_flags_next     = '1;
        separator_was_space_next  = 1'b0;
        param_char_count_next     = '0;
        value_accumulator_next    = '0;
        line_overflowed_next      = 1'b0;
        carriage_return_seen_next = 1'b0;
      end else if (!line_overflowed) begin
        for (int k = 0; k < apcd_pkg::NAME_COUNT; k++) begin
          if (line_position < apcd_pkg::LINE_POS_W'(apcd_pkg::NAME_LEN[k])) begin
            if (rx_byte != apcd_pkg::name_char(k, apcd_pkg::NAME_POS_W'(line_position))) begin
              name_match_flags_next[k] = 1'b0;
            end
          end
        end
        if (rx_byte == apcd_pkg::CH_CR) begin
          carriage_return_seen_next = 1'b1;
        end else if (!carriage_return_seen) begin
          if (line_position == apcd_pkg::LINE_POS_W'(apcd_pkg::SETV_LEN)) begin
            separator_was_space_next = (rx_byte == apcd_pkg::CH_SP);
          end else if (line_position > apcd_pkg::LINE_POS_W'(apcd_pkg::SETV_LEN) &&
                       param_char_count < apcd_pkg::PCNT_W'(apcd_pkg::MAX_PARAM_CHARS)) begin
            param_char_count_next = param_char_count + 1'b1;
            if (is_digit) begin
              value_accumulator_next =
                (acc_ext > apcd_pkg::ACC_EXT_W'(apcd_pkg::VALUE_CAP)) ?
                apcd_pkg::VALUE_CAP : acc_ext[apcd_pkg::MV_W-1:0];
            end
          end
        end
        line_position_next = line_position + 1'b1;
        if (line_position_next >= apcd_pkg::LINE_POS_W'(apcd_pkg::LINE_MAX)) begin
          line_overflowed_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_position        <= '0;
      name_match_flags     <= '1;
      separator_was_space  <= 1'b0;
      param_char_count     <= '0;
      value_accumulator    <= '0;
      line_overflowed      <= 1'b0;
      carriage_return_seen <= 1'b0;
    end else begin
      line_position        <= line_position_next;
      name_match_flags     <= name_match_flags_next;
      separator_was_space  <= separator_was_space_next;
      param_char_count     <= param_char_count_next;
      value_accumulator    <= value_accumulator_next;
      line_overflowed      <= line_overflowed_next;
      carriage_return_seen <= carriage_return_seen_next;
    end
  end

endmodule

/* hdl/apcd_cmd_fifo.sv */
module apcd_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  apcd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output apcd_pkg::cmd_t pop_cmd
);

  apcd_pkg::cmd_t                 entries [apcd_pkg::CMD_FIFO_DEPTH];
  logic [apcd_pkg::CMD_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [apcd_pkg::CMD_CNT_W-1:0] count;
  logic                           do_push, do_pop;

  assign full      = (count == apcd_pkg::CMD_CNT_W'(apcd_pkg::CMD_FIFO_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/apcd_back.sv */
module apcd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  apcd_pkg::cmd_t    in_cmd,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output apcd_pkg::result_t out_result
);

  logic                               s1_valid;
  apcd_pkg::cmd_t                     s1_cmd;
  logic [apcd_pkg::DAC_W-1:0]         s1_quot;
  logic [apcd_pkg::STEP_W-1:0]        s1_step;
  logic                               s1_ready, out_free;

  logic [apcd_pkg::DAC_PROD_W-1:0]    prod;
  logic [apcd_pkg::STEP_W-1:0]        step_calc;
  logic [apcd_pkg::DAC_NUM_W-1:0]     num, back, rem;
  logic [apcd_pkg::DAC_W-1:0]         dac_fixed;

  assign out_free = !out_valid || out_ready;
  assign s1_ready = !s1_valid || out_free;
  assign in_ready = s1_ready;

  assign prod = apcd_pkg::DAC_PROD_W'(in_cmd.millivolts) *
                apcd_pkg::DAC_PROD_W'(apcd_pkg::DAC_RECIP);

  always_comb begin
    step_calc = '0;
    for (int i = 0; i < apcd_pkg::STEP_COUNT; i++) begin
      if (in_cmd.millivolts > apcd_pkg::STEP_THRESH[i]) begin
        step_calc = step_calc + 1'b1;
      end
    end
  end

  assign num  = {s1_cmd.millivolts, 6'b0};
  assign back = apcd_pkg::DAC_NUM_W'(s1_quot) * apcd_pkg::DAC_NUM_W'(apcd_pkg::DAC_DIV);
  assign rem  = num - back;
  assign dac_fixed = (rem >= apcd_pkg::DAC_NUM_W'(apcd_pkg::DAC_DIV)) ?
                     s1_quot + 1'b1 : s1_quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_cmd  <= in_cmd;
      s1_quot <= prod[apcd_pkg::DAC_SHIFT +: apcd_pkg::DAC_W];
      s1_step <= step_calc;
    end
    if (out_free && s1_valid) begin
      out_result.command_code <= s1_cmd.code;
      out_result.value_valid  <= s1_cmd.value_valid;
      out_result.millivolts   <= s1_cmd.millivolts;
      out_result.supply_step  <= s1_cmd.value_valid ? s1_step : '0;
      out_result.dac_code     <= s1_cmd.value_valid ? dac_fixed : '0;
    end
  end

endmodule

/* tb/tb_ascii_power_command_decoder.sv */
module tb_ascii_power_command_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 3000;
  localparam int RANDOM_BYTES = 460;
  localparam int DRAIN_CYCLES = 20;

  typedef logic [7:0] byte_q_t [$];

  typedef struct {
    logic [7:0]        ch;
    bit                typed;
    bit                fires;
    apcd_pkg::result_t want;
  } rx_word_t;

  typedef struct {
    string             head;
    int                raw;
    bit                cr;
    string             tail;
    bit                typed;
    bit                fires;
    apcd_pkg::result_t want;
  } line_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  ascii_power_command_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  string     cmd_text [5] = '{"power on", "power off", "set voltage", "get voltage",
                              "get current"};
  apcd_pkg::cmd_code_t cmd_of [5] = '{apcd_pkg::CMD_POWER_ON, apcd_pkg::CMD_POWER_OFF,
                                      apcd_pkg::CMD_SET_VOLTAGE, apcd_pkg::CMD_GET_VOLTAGE,
                                      apcd_pkg::CMD_GET_CURRENT};

  rx_word_t          rx_bytes_q [$];
  apcd_pkg::result_t pending_results [$];
  int        err_count = 0;
  int        stall_cycles = 0;
  int        src_idle_pct = 29;
  int        snk_idle_pct = 77;

  // decoder line state
  int unsigned line_pos;
  logic [4:0]  live_names;
  bit          sep_space;
  bit          cr_seen;
  bit          overflowed;
  int unsigned param_count;
  int unsigned mv_acc;

  function automatic void clear_line_state();
    line_pos    = 0;
    live_names  = '1;
    sep_space   = 1'b0;
    cr_seen     = 1'b0;
    overflowed  = 1'b0;
    param_count = 0;
    mv_acc      = 0;
  endfunction

  task automatic decode_byte(input logic [7:0] b, output bit fires,
                             output apcd_pkg::result_t r);
    apcd_pkg::cmd_code_t code;
    bit          valid;
    int unsigned mv;
    int unsigned step;
    fires = 1'b0;
    r = '0;
    if (b == apcd_pkg::CH_LF) begin
      if (!overflowed && line_pos != 0) begin
        code = apcd_pkg::CMD_INVALID;
        for (int k = 4; k >= 0; k--) begin
          if (live_names[k] && line_pos >= cmd_text[k].len()) code = cmd_of[k];
        end
        valid = (code == apcd_pkg::CMD_SET_VOLTAGE) && sep_space;
        mv = valid ? mv_acc : 0;
        step = 0;
        for (int unsigned t = 5000; t <= 12000; t += 1000) begin
          if (mv + 1000 > t) step++;
        end
        r.command_code = code;
        r.value_valid  = valid;
        r.millivolts   = 17'(mv);
        r.supply_step  = 4'(step);
        r.dac_code     = 15'(mv * 64 / 375);
        fires = 1'b1;
      end
      clear_line_state();
    end else if (!overflowed) begin
      for (int k = 0; k < 5; k++) begin
        if (line_pos < cmd_text[k].len() && b != cmd_text[k][line_pos]) live_names[k] = 1'b0;
      end
      if (b == apcd_pkg::CH_CR) begin
        cr_seen = 1'b1;
      end else if (!cr_seen) begin
        if (line_pos == apcd_pkg::SETV_LEN) begin
          sep_space = (b == apcd_pkg::CH_SP);
        end else if (line_pos > apcd_pkg::SETV_LEN &&
                     param_count < apcd_pkg::MAX_PARAM_CHARS) begin
          param_count++;
          if (b >= apcd_pkg::CH_ZERO && b <= apcd_pkg::CH_NINE) begin
            mv_acc = mv_acc * 10 + 32'(b - apcd_pkg::CH_ZERO);
            if (mv_acc > apcd_pkg::VALUE_CAP) mv_acc = 32'(apcd_pkg::VALUE_CAP);
          end
        end
      end
      line_pos++;
      if (line_pos >= apcd_pkg::LINE_MAX) overflowed = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    apcd_pkg::result_t got;
    apcd_pkg::result_t want;
    bit      fires;
    bit      moved;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
      clear_line_state();
    end else begin
      moved = 1'b0;
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        got = m_tdata;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got code %0d mv %0d",
                   $time, got.command_code, got.millivolts);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("command_code", want.command_code, got.command_code);
          check_field("value_valid", want.value_valid, got.value_valid);
          check_field("millivolts", want.millivolts, got.millivolts);
          check_field("supply_step", want.supply_step, got.supply_step);
          check_field("dac_code", want.dac_code, got.dac_code);
        end
      end
      if (s_tvalid && s_tready) begin
        moved = 1'b1;
        decode_byte(rx_bytes_q[0].ch, fires, want);
        if (rx_bytes_q[0].typed) begin
          if (rx_bytes_q[0].fires) pending_results.push_back(rx_bytes_q[0].want);
        end else if (fires) begin
          pending_results.push_back(want);
        end
        void'(rx_bytes_q.pop_front());
      end
      if (!(s_tvalid && !s_tready)) begin
        if (rx_bytes_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= rx_bytes_q[0].ch;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= $urandom_range(0, 99) >= snk_idle_pct;
      stall_cycles <= moved ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("tb_ascii_power_command_decoder: done, errors");
    $finish;
  end

  task automatic send_line(input byte_q_t bytes, input bit typed, input bit fires,
                           input apcd_pkg::result_t want);
    rx_word_t w;
    while (rx_bytes_q.size() > 32) @(negedge clk);
    foreach (bytes[i]) begin
      w.ch    = bytes[i];
      w.typed = typed && (i == bytes.size() - 1);
      w.fires = fires;
      w.want  = want;
      rx_bytes_q.push_back(w);
    end
  endtask

  function automatic logic [7:0] any_but_lf();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == apcd_pkg::CH_LF) b = 8'h0b;
    return b;
  endfunction

  function automatic apcd_pkg::result_t make_res(apcd_pkg::cmd_code_t c, bit v, int mv,
                                                 int st, int dac);
    apcd_pkg::result_t r;
    r.command_code = c;
    r.value_valid  = v;
    r.millivolts   = 17'(mv);
    r.supply_step  = 4'(st);
    r.dac_code     = 15'(dac);
    return r;
  endfunction

  initial begin
    line_row_t rows [$];
    byte_q_t   line;
    string     digits;
    int        sent;
    int        pick;
    int        k;
    int        n;
    int        r;

    rows.push_back('{"", -1, 0, "", 1, 0, '0});
    rows.push_back('{"power on", -1, 1, "", 1, 1,
                     make_res(apcd_pkg::CMD_POWER_ON, 0, 0, 0, 0)});
    rows.push_back('{"power off", -1, 1, "", 1, 1,
                     make_res(apcd_pkg::CMD_POWER_OFF, 0, 0, 0, 0)});
    rows.push_back('{"get voltage", -1, 0, "", 1, 1,
                     make_res(apcd_pkg::CMD_GET_VOLTAGE, 0, 0, 0, 0)});
    rows.push_back('{"get current now", -1, 1, "", 1, 1,
                     make_res(apcd_pkg::CMD_GET_CURRENT, 0, 0, 0, 0)});
    rows.push_back('{"power", -1, 1, "", 1, 1,
                     make_res(apcd_pkg::CMD_INVALID, 0, 0, 0, 0)});
    rows.push_back('{"sET voltage 5", -1, 1, "", 1, 1,
                     make_res(apcd_pkg::CMD_INVALID, 0, 0, 0, 0)});
    rows.push_back('{"set voltage 99999", -1, 1, "", 1, 1,
                     make_res(apcd_pkg::CMD_SET_VOLTAGE, 1, 99999, 8, 17066)});
    rows.push_back('{"set voltage 0", -1, 1, "", 1, 1,
                     make_res(apcd_pkg::CMD_SET_VOLTAGE, 1, 0, 0, 0)});
    rows.push_back('{"set voltage", -1, 1, "", 1, 1,
                     make_res(apcd_pkg::CMD_SET_VOLTAGE, 0, 0, 0, 0)});
    rows.push_back('{"set voltage,5000", -1, 0, "", 1, 1,
                     make_res(apcd_pkg::CMD_SET_VOLTAGE, 0, 0, 0, 0)});
    rows.push_back('{"set voltage 4000", -1, 1, "", 0, 0, '0});
    rows.push_back('{"set voltage 4001", -1, 1, "", 0, 0, '0});
    rows.push_back('{"set voltage 11000", -1, 1, "", 0, 0, '0});
    rows.push_back('{"set voltage 11001", -1, 0, "", 0, 0, '0});
    rows.push_back('{"set voltage  1 2x3", -1, 1, "", 0, 0, '0});
    rows.push_back('{"set voltage 12", -1, 1, "34", 0, 0, '0});
    rows.push_back('{"set voltage 7", 8'hff, 1, "", 0, 0, '0});
    rows.push_back('{"", 8'h00, 0, "", 1, 1, make_res(apcd_pkg::CMD_INVALID, 0, 0, 0, 0)});
    rows.push_back('{"xxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxx", -1, 1, "", 1, 0, '0});
    rows.push_back('{"get current abcdefghijklmnopqrstuvwxyz0", -1, 0, "", 0, 0, '0});
    rows.push_back('{"get current abcdefghijklmnopqrstuvwxyz01", -1, 0, "", 0, 0, '0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      line = {};
      for (int j = 0; j < rows[i].head.len(); j++) line.push_back(rows[i].head[j]);
      if (rows[i].raw >= 0) line.push_back(8'(rows[i].raw));
      if (rows[i].cr) line.push_back(apcd_pkg::CH_CR);
      for (int j = 0; j < rows[i].tail.len(); j++) line.push_back(rows[i].tail[j]);
      line.push_back(apcd_pkg::CH_LF);
      send_line(line, rows[i].typed, rows[i].fires, rows[i].want);
    end

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if (sent >= 2 * RANDOM_BYTES / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else if (sent >= RANDOM_BYTES / 3) begin
        src_idle_pct = 77;
        snk_idle_pct = 29;
      end
      line = {};
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        k = $urandom_range(0, 4);
        for (int j = 0; j < cmd_text[k].len(); j++) line.push_back(cmd_text[k][j]);
        if (cmd_of[k] == apcd_pkg::CMD_SET_VOLTAGE) begin
          line.push_back($urandom_range(0, 9) < 8 ? apcd_pkg::CH_SP : any_but_lf());
          if ($urandom_range(0, 2) == 0) begin
            digits = $sformatf("%0d", $urandom_range(0, 12000));
            for (int j = 0; j < digits.len(); j++) line.push_back(digits[j]);
          end else begin
            repeat ($urandom_range(0, 7)) begin
              r = $urandom_range(0, 99);
              if (r < 70) line.push_back(apcd_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
              else if (r < 85) line.push_back(apcd_pkg::CH_SP);
              else line.push_back(any_but_lf());
            end
          end
        end else begin
          repeat ($urandom_range(0, 3)) line.push_back(8'($urandom_range(33, 126)));
        end
        if ($urandom_range(0, 99) < 85) begin
          line.push_back(apcd_pkg::CH_CR);
          if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) begin
              line.push_back(apcd_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            end
          end
        end
      end else if (pick < 70) begin
        k = $urandom_range(0, 4);
        n = $urandom_range(1, cmd_text[k].len());
        for (int j = 0; j < n; j++) line.push_back(cmd_text[k][j]);
        if ($urandom_range(0, 1) == 1) line[$urandom_range(0, n - 1)] = any_but_lf();
      end else if (pick < 78) begin
        // lone line feed
      end else if (pick < 86) begin
        repeat ($urandom_range(38, 50)) line.push_back(any_but_lf());
      end else begin
        repeat ($urandom_range(1, 20)) line.push_back(8'($urandom_range(0, 255)));
      end
      line.push_back(apcd_pkg::CH_LF);
      send_line(line, 1'b0, 1'b0, '0);
      sent += line.size();
    end

    while (rx_bytes_q.size() > 0 || pending_results.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("tb_ascii_power_command_decoder: done, clean");
    end else begin
      $display("tb_ascii_power_command_decoder: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/apcd_pkg.sv
hdl/apcd_front.sv
hdl/apcd_cmd_fifo.sv
hdl/apcd_back.sv
hdl/ascii_power_command_decoder.sv
tb/tb_ascii_power_command_decoder.sv
